@@ hdl/crl_pkg.sv @@
// shared types and constants of the clipped line rasteriser
package crl_pkg;

	localparam int ADDR_W  = 24;
	localparam int COLOR_W = 24;
	localparam int IDX_W   = 2;

	// outcode bits
	localparam logic [3:0] OUT_N = 4'h8;
	localparam logic [3:0] OUT_S = 4'h4;
	localparam logic [3:0] OUT_E = 4'h2;
	localparam logic [3:0] OUT_W = 4'h1;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	localparam logic [1:0] ST_NONE   = 2'd0;
	localparam logic [1:0] ST_PIXEL  = 2'd1;
	localparam logic [1:0] ST_ACCEPT = 2'd2;
	localparam logic [1:0] ST_REJECT = 2'd3;

	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_PT,
		S_MUL,
		S_DIVGO,
		S_DIV,
		S_APPLY,
		S_NEXT,
		S_FINAL,
		S_SETUP,
		S_REJECT
	} state_t;

endpackage

@@ hdl/crl_req_if.sv @@
// request channel: start and tick words
interface crl_req_if import crl_pkg::*; #(parameter int COORD_BITS = 16) ();
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic [COLOR_W-1:0]           draw_color;

	modport source (output valid, func, start_x, start_y, end_x, end_y, draw_color,
		input ready);
	modport sink (input valid, func, start_x, start_y, end_x, end_y, draw_color,
		output ready);
endinterface

@@ hdl/crl_rsp_if.sv @@
// response channel: status and pixel words
interface crl_rsp_if import crl_pkg::*; #(parameter int SCREEN_BITS = 12) ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             status;
	logic [SCREEN_BITS-1:0] pixel_x;
	logic [SCREEN_BITS-1:0] pixel_y;
	logic [ADDR_W-1:0]      pixel_addr;
	logic [COLOR_W-1:0]     pixel_color;
	logic                   last_pixel;

	modport source (output valid, status, pixel_x, pixel_y, pixel_addr, pixel_color,
		last_pixel, input ready);
	modport sink (input valid, status, pixel_x, pixel_y, pixel_addr, pixel_color,
		last_pixel, output ready);
endinterface

@@ hdl/crl_div.sv @@
// unsigned restoring divider, one quotient bit per cycle
module crl_div #(
	parameter int NUM_W = 38,
	parameter int DEN_W = 19
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

@@ hdl/clipped_line_rasterizer_top.sv @@
// clipped line rasteriser: outcode clip, iterative intersection, bresenham stepping
//
// req carries start words (func 0: two signed endpoints and a colour) and tick
// words (func 1). rsp returns exactly one word per request word.
// A start word is answered with status accepted or rejected. Each clipped
// endpoint needs one or two passes through the shared multiplier and the
// bit-serial divider, whose divisor is XW bits wide (XW is the working
// coordinate width, 18 bits at the default sizes).
// A tick word is answered in the cycle after acceptance with the next pixel
// (x, y, row*width+column address, colour, last flag) or status none when no
// line is active; ticks are taken every cycle while rsp keeps up.
// The result sits in an output register; req stays ready for a tick while that
// word waits only if rsp takes it in the same cycle.
// Screen width and height are to be written on the wr_* port while idle; the
// block does not enforce this. Reset gives 640 by 480 and no active line.
module clipped_line_rasterizer_top import crl_pkg::*; #(
	parameter int COORD_BITS  = 16,
	parameter int SCREEN_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	crl_req_if.sink              req,
	crl_rsp_if.source            rsp,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_index,
	input  logic [SCREEN_BITS:0] wr_data
);
	localparam int S  = SCREEN_BITS;
	localparam int SW = SCREEN_BITS + 1;
	localparam int EW = ((COORD_BITS > SCREEN_BITS + 2) ? COORD_BITS : SCREEN_BITS + 2) + 1;
	localparam int XW = EW + 1;
	localparam int PW = 2 * XW;
	localparam int EB = SCREEN_BITS + 2;
	localparam int AW = 2 * SCREEN_BITS + 2;

	typedef logic signed [XW-1:0] crd_t;

	function automatic logic [3:0] outcode(input crd_t x, input crd_t y,
		input crd_t mxv, input crd_t myv);
		logic [3:0] c;
		c = '0;
		if (y < 0) c = c | OUT_N;
		else if (y > myv) c = c | OUT_S;
		if (x < 0) c = c | OUT_W;
		else if (x > mxv) c = c | OUT_E;
		return c;
	endfunction

	// configuration
	logic [SW-1:0] width_q, height_q;
	logic [SW-1:0] eff_w, eff_h;
	crd_t          mx, my;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SW'(640);
			height_q <= SW'(480);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WIDTH:  width_q  <= wr_data;
				REG_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign eff_w = width_q[S]  ? {1'b1, {S{1'b0}}} : width_q;
	assign eff_h = height_q[S] ? {1'b1, {S{1'b0}}} : height_q;
	assign mx    = $signed(XW'(eff_w)) - crd_t'(1);
	assign my    = $signed(XW'(eff_h)) - crd_t'(1);

	// sequencer and clip datapath
	state_t state_q, state_d;
	crd_t   ox1_q, oy1_q, ox2_q, oy2_q;
	crd_t   cx1_q, cy1_q, cx2_q, cy2_q;
	logic [3:0] code1_q, code2_q;
	logic   pt_q, vert_q;
	logic [COLOR_W-1:0] color_q;
	logic signed [PW-1:0] prod_q;
	crd_t   den_q, base_q, edge_q, qv_q;

	// bresenham state
	logic          line_active_q;
	logic [S-1:0]  cur_x_q, cur_y_q;
	logic signed [EB-1:0] err_q;
	logic [SW-1:0] remain_q;
	logic [S-1:0]  dmaj_q, dmin_q;
	logic          xneg_q, yneg_q, xmaj_q;

	// output register
	logic          out_valid_q;
	logic [1:0]    o_status_q;
	logic [S-1:0]  o_x_q, o_y_q;
	logic [ADDR_W-1:0]  o_addr_q;
	logic [COLOR_W-1:0] o_color_q;
	logic          o_last_q;
	logic          out_free;
	logic          accept;

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;

	crd_t in_x1, in_y1, in_x2, in_y2;
	assign in_x1 = XW'(req.start_x);
	assign in_y1 = XW'(req.start_y);
	assign in_x2 = XW'(req.end_x);
	assign in_y2 = XW'(req.end_y);

	// operands of the current intersection
	logic [3:0] pcode;
	crd_t px, py, qx, qy, edge_v, num_a, num_b, den_v, base_v;
	logic signed [PW-1:0] prod_v;

	assign pcode  = pt_q ? code2_q : code1_q;
	assign px     = pt_q ? ox2_q : ox1_q;
	assign py     = pt_q ? oy2_q : oy1_q;
	assign qx     = pt_q ? ox1_q : ox2_q;
	assign qy     = pt_q ? oy1_q : oy2_q;
	assign edge_v = vert_q ? (((pcode & OUT_W) != '0) ? crd_t'(0) : mx)
	                       : (((pcode & OUT_N) != '0) ? crd_t'(0) : my);
	assign num_a  = edge_v - (vert_q ? px : py);
	assign num_b  = vert_q ? (qy - py) : (qx - px);
	assign den_v  = vert_q ? (qx - px) : (qy - py);
	assign base_v = vert_q ? py : px;
	assign prod_v = PW'(num_a) * PW'(num_b);

	// divider
	logic            div_start, div_done;
	logic [PW-1:0]   div_quo, prod_mag;
	logic [XW-1:0]   den_mag;
	logic            q_neg;
	crd_t            q_signed;

	assign prod_mag  = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
	assign den_mag   = den_q[XW-1] ? XW'(-den_q) : XW'(den_q);
	assign q_neg     = prod_q[PW-1] ^ den_q[XW-1];
	assign div_start = (state_q == S_DIVGO) && (den_q != '0);
	assign q_signed  = q_neg ? -$signed(div_quo[XW-1:0]) : $signed(div_quo[XW-1:0]);

	crl_div #(.NUM_W(PW), .DEN_W(XW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_mag),
		.den    (den_mag),
		.done   (div_done),
		.quo    (div_quo)
	);

	crd_t res_v;
	logic res_out;
	assign res_v   = base_q + qv_q;
	assign res_out = (res_v < 0) || (res_v > mx);

	logic clipped_ok;
	assign clipped_ok = (cx1_q >= 0) && (cx1_q <= mx) && (cy1_q >= 0) && (cy1_q <= my) &&
	                    (cx2_q >= 0) && (cx2_q <= mx) && (cy2_q >= 0) && (cy2_q <= my);

	// line setup
	crd_t dx_v, dy_v, adx_v, ady_v;
	logic [S-1:0] adx_s, ady_s, smaj, smin;
	logic         sxmaj;
	assign dx_v  = cx2_q - cx1_q;
	assign dy_v  = cy2_q - cy1_q;
	assign adx_v = dx_v[XW-1] ? -dx_v : dx_v;
	assign ady_v = dy_v[XW-1] ? -dy_v : dy_v;
	assign adx_s = adx_v[S-1:0];
	assign ady_s = ady_v[S-1:0];
	assign sxmaj = adx_s > ady_s;
	assign smaj  = sxmaj ? adx_s : ady_s;
	assign smin  = sxmaj ? ady_s : adx_s;

	// tick datapath
	logic [AW-1:0]        addr_full;
	logic signed [EB-1:0] err_n;
	logic                 err_pos;
	logic [S-1:0]         x_inc, y_inc;
	assign addr_full = AW'(cur_y_q) * AW'(eff_w) + AW'(cur_x_q);
	assign err_pos   = !err_q[EB-1];
	assign err_n     = err_q - (err_pos ? $signed({1'b0, dmaj_q, 1'b0}) : EB'(0))
	                   + $signed({1'b0, dmin_q, 1'b0});
	assign x_inc     = xneg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
	assign y_inc     = yneg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (accept && req.func == FUNC_START) state_d = S_START;
			S_START: begin
				if ((code1_q & code2_q) != '0) state_d = S_REJECT;
				else if (code1_q == '0 && code2_q == '0) state_d = S_SETUP;
				else state_d = S_PT;
			end
			S_PT:     state_d = (pcode == '0) ? S_NEXT : S_MUL;
			S_MUL:    state_d = S_DIVGO;
			S_DIVGO:  state_d = (den_q == '0) ? S_APPLY : S_DIV;
			S_DIV:    if (div_done) state_d = S_APPLY;
			S_APPLY: begin
				if (!vert_q && ((pcode & (OUT_E | OUT_W)) != '0) && res_out) state_d = S_MUL;
				else state_d = S_NEXT;
			end
			S_NEXT:   state_d = pt_q ? S_FINAL : S_PT;
			S_FINAL:  state_d = clipped_ok ? S_SETUP : S_REJECT;
			S_SETUP:  if (out_free) state_d = S_IDLE;
			S_REJECT: if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// clip registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.func == FUNC_START) begin
					ox1_q   <= in_x1;
					oy1_q   <= in_y1;
					ox2_q   <= in_x2;
					oy2_q   <= in_y2;
					cx1_q   <= in_x1;
					cy1_q   <= in_y1;
					cx2_q   <= in_x2;
					cy2_q   <= in_y2;
					code1_q <= outcode(in_x1, in_y1, mx, my);
					code2_q <= outcode(in_x2, in_y2, mx, my);
					color_q <= req.draw_color;
					pt_q    <= 1'b0;
				end
			end
			S_PT: vert_q <= ((pcode & (OUT_N | OUT_S)) == '0);
			S_MUL: begin
				prod_q <= prod_v;
				den_q  <= den_v;
				base_q <= base_v;
				edge_q <= edge_v;
			end
			S_DIVGO: if (den_q == '0) qv_q <= '0;
			S_DIV:   if (div_done) qv_q <= q_signed;
			S_APPLY: begin
				if (!vert_q && ((pcode & (OUT_E | OUT_W)) != '0) && res_out) begin
					// corner point missed the horizontal edge: try the vertical one
					vert_q <= 1'b1;
				end else if (pt_q) begin
					cx2_q <= vert_q ? edge_q : res_v;
					cy2_q <= vert_q ? res_v : edge_q;
				end else begin
					cx1_q <= vert_q ? edge_q : res_v;
					cy1_q <= vert_q ? res_v : edge_q;
				end
			end
			S_NEXT: pt_q <= 1'b1;
			default: ;
		endcase
	end

	// line state and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q <= 1'b0;
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			err_q         <= '0;
			remain_q      <= '0;
			dmaj_q        <= '0;
			dmin_q        <= '0;
			xneg_q        <= 1'b0;
			yneg_q        <= 1'b0;
			xmaj_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if ((accept && req.func == FUNC_TICK) ||
				((state_q == S_REJECT || state_q == S_SETUP) && out_free))
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			if (accept && req.func == FUNC_START) line_active_q <= 1'b0;
			if (accept && req.func == FUNC_TICK) begin
				if (line_active_q) begin
					if (remain_q == '0) begin
						line_active_q <= 1'b0;
					end else begin
						remain_q <= remain_q - 1'b1;
						err_q    <= err_n;
						if (xmaj_q) begin
							cur_x_q <= x_inc;
							if (err_pos) cur_y_q <= y_inc;
						end else begin
							cur_y_q <= y_inc;
							if (err_pos) cur_x_q <= x_inc;
						end
					end
				end
			end
			if (state_q == S_SETUP && out_free) begin
				line_active_q <= 1'b1;
				xneg_q        <= dx_v[XW-1];
				yneg_q        <= dy_v[XW-1];
				xmaj_q        <= sxmaj;
				dmaj_q        <= smaj;
				dmin_q        <= smin;
				err_q         <= $signed({1'b0, smin, 1'b0}) - $signed({2'b00, smaj});
				remain_q      <= {1'b0, smaj};
				cur_x_q       <= cx1_q[S-1:0];
				cur_y_q       <= cy1_q[S-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.func == FUNC_TICK) begin
			o_status_q <= line_active_q ? ST_PIXEL : ST_NONE;
			o_x_q      <= line_active_q ? cur_x_q : '0;
			o_y_q      <= line_active_q ? cur_y_q : '0;
			o_addr_q   <= line_active_q ? ADDR_W'(addr_full) : '0;
			o_color_q  <= line_active_q ? color_q : '0;
			o_last_q   <= line_active_q && (remain_q == '0);
		end else if ((state_q == S_REJECT || state_q == S_SETUP) && out_free) begin
			o_status_q <= (state_q == S_SETUP) ? ST_ACCEPT : ST_REJECT;
			o_x_q      <= '0;
			o_y_q      <= '0;
			o_addr_q   <= '0;
			o_color_q  <= '0;
			o_last_q   <= 1'b0;
		end
	end

	// line colour is only shown on pixels
	logic [COLOR_W-1:0] line_color_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) line_color_q <= '0;
		else if (state_q == S_SETUP && out_free) line_color_q <= color_q;
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = o_status_q;
	assign rsp.pixel_x     = o_x_q;
	assign rsp.pixel_y     = o_y_q;
	assign rsp.pixel_addr  = o_addr_q;
	assign rsp.pixel_color = (o_status_q == ST_PIXEL) ? line_color_q : o_color_q;
	assign rsp.last_pixel  = o_last_q;

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.func == FUNC_START) |=> !line_active_q)
		else $error("start word left a line active");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside its wait state");

	a_remain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		line_active_q |-> (remain_q <= {1'b0, dmaj_q}))
		else $error("pixel count above major delta");
endmodule

@@ tb/tb_clipped_line_rasterizer_top.sv @@
// testbench of the clipped line rasteriser: directed table, random lines, pixel checks
module tb_clipped_line_rasterizer_top;
	import crl_pkg::*;

	localparam int  XB        = 16;
	localparam int  SB        = 12;
	localparam longint LIMIT  = 3_000_000;

	typedef struct packed {
		logic [1:0]    status;
		logic [SB-1:0] px;
		logic [SB-1:0] py;
		logic [23:0]   addr;
		logic [23:0]   color;
		logic          last;
	} pixel_word_t;

	typedef struct {
		logic           func;
		int             sx, sy, ex, ey;
		logic [23:0]    color;
		bit             typed;
		logic [1:0]     typed_status;
	} line_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [IDX_W-1:0] wr_index = REG_WIDTH;
	logic [SB:0] wr_data = '0;

	crl_req_if #(.COORD_BITS(XB)) req_ch ();
	crl_rsp_if #(.SCREEN_BITS(SB)) rsp_ch ();

	clipped_line_rasterizer_top #(.COORD_BITS(XB), .SCREEN_BITS(SB)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	longint      scr_w = 640, scr_h = 480;
	bit          drawing, xs_neg, ys_neg, x_major;
	logic [SB-1:0] pos_x, pos_y;
	int          bres_err, pix_left, d_major, d_minor;
	logic [23:0] ink;

	pixel_word_t pixels_due[$];
	int          mismatches = 0;
	longint      cycles = 0;
	bit          quiet = 1'b0;
	bit          want_hold = 1'b0;

	function automatic longint clamp_size(longint v);
		return (v > (1 << SB)) ? (1 << SB) : v;
	endfunction

	function automatic logic [3:0] region(longint x, longint y, longint mx, longint my);
		logic [3:0] c;
		c = '0;
		if (y < 0) c |= OUT_N;
		else if (y > my) c |= OUT_S;
		if (x < 0) c |= OUT_W;
		else if (x > mx) c |= OUT_E;
		return c;
	endfunction

	function automatic void to_edge(inout longint px, inout longint py, input longint qx,
		input longint qy, input logic [3:0] code, input longint mx, input longint my);
		longint x0, y0, x, y, xe, ye;
		x0 = px; y0 = py; x = x0; y = y0;
		if (code & (OUT_N | OUT_S)) begin
			ye = (code & OUT_N) ? 0 : my;
			if (qy != y0) x = x0 + (ye - y0) * (qx - x0) / (qy - y0);
			y = ye;
			// corner: fall back to the vertical edge
			if ((code & (OUT_E | OUT_W)) && (x < 0 || x > mx)) begin
				xe = (code & OUT_W) ? 0 : mx;
				if (qx != x0) y = y0 + (xe - x0) * (qy - y0) / (qx - x0);
				x = xe;
			end
		end else if (code & (OUT_E | OUT_W)) begin
			xe = (code & OUT_W) ? 0 : mx;
			if (qx != x0) y = y0 + (xe - x0) * (qy - y0) / (qx - x0);
			x = xe;
		end
		px = x;
		py = y;
	endfunction

	function automatic logic [1:0] begin_line(longint x1, longint y1, longint x2, longint y2,
		logic [23:0] colour);
		longint mx, my, ox, oy, dx, dy;
		logic [3:0] c1, c2;
		mx = clamp_size(scr_w) - 1;
		my = clamp_size(scr_h) - 1;
		c1 = region(x1, y1, mx, my);
		c2 = region(x2, y2, mx, my);
		drawing = 1'b0;
		if ((c1 & c2) != 0) return ST_REJECT;
		if (c1 != 0 || c2 != 0) begin
			ox = x1; oy = y1;
			to_edge(x1, y1, x2, y2, c1, mx, my);
			to_edge(x2, y2, ox, oy, c2, mx, my);
			if (x1 < 0 || x1 > mx || y1 < 0 || y1 > my ||
				x2 < 0 || x2 > mx || y2 < 0 || y2 > my)
				return ST_REJECT;
		end
		dx = x2 - x1;
		dy = y2 - y1;
		xs_neg = dx < 0;
		ys_neg = dy < 0;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		x_major = dx > dy;
		d_major = int'(x_major ? dx : dy);
		d_minor = int'(x_major ? dy : dx);
		bres_err = 2 * d_minor - d_major;
		pix_left = d_major;
		pos_x = x1[SB-1:0];
		pos_y = y1[SB-1:0];
		ink = colour;
		drawing = 1'b1;
		return ST_ACCEPT;
	endfunction

	function automatic pixel_word_t next_pixel();
		pixel_word_t w;
		longint a;
		w = '0;
		if (!drawing) return w;
		a = longint'(pos_y) * clamp_size(scr_w) + longint'(pos_x);
		w.status = ST_PIXEL;
		w.px = pos_x;
		w.py = pos_y;
		w.addr = a[23:0];
		w.color = ink;
		w.last = (pix_left == 0);
		if (pix_left == 0) begin
			drawing = 1'b0;
			return w;
		end
		pix_left--;
		if (bres_err >= 0) begin
			bres_err -= 2 * d_major;
			if (x_major) pos_y = ys_neg ? pos_y - 1'b1 : pos_y + 1'b1;
			else pos_x = xs_neg ? pos_x - 1'b1 : pos_x + 1'b1;
		end
		bres_err += 2 * d_minor;
		if (x_major) pos_x = xs_neg ? pos_x - 1'b1 : pos_x + 1'b1;
		else pos_y = ys_neg ? pos_y - 1'b1 : pos_y + 1'b1;
		return w;
	endfunction

	function automatic int gap_len();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 80);
	endfunction

	task automatic send_word(line_row_t row);
		pixel_word_t w;
		int n;
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.func = row.func;
		req_ch.start_x = row.sx[XB-1:0];
		req_ch.start_y = row.sy[XB-1:0];
		req_ch.end_x = row.ex[XB-1:0];
		req_ch.end_y = row.ey[XB-1:0];
		req_ch.draw_color = row.color;
		do @(posedge clk); while (!req_ch.ready);
		if (row.func == FUNC_START) begin
			w = '0;
			w.status = begin_line(longint'(signed'(row.sx[XB-1:0])),
				longint'(signed'(row.sy[XB-1:0])), longint'(signed'(row.ex[XB-1:0])),
				longint'(signed'(row.ey[XB-1:0])), row.color);
		end else begin
			w = next_pixel();
		end
		if (row.typed) begin
			w = '0;
			w.status = row.typed_status;
		end
		pixels_due.push_back(w);
		n = gap_len();
		if (n > 0) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		// withdraw the last word before it can be taken a second time
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, int val);
		wait_drained();
		@(negedge clk);
		req_ch.valid = 1'b0;
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = val[SB:0];
		@(negedge clk);
		wr_en = 1'b0;
		@(posedge clk);
		if (idx == REG_WIDTH) scr_w = val[SB:0];
		else scr_h = val[SB:0];
	endtask

	function automatic line_row_t tick_row();
		line_row_t r;
		r.func = FUNC_TICK;
		r.sx = $urandom; r.sy = $urandom; r.ex = $urandom; r.ey = $urandom;
		r.color = 24'($urandom);
		r.typed = 1'b0;
		r.typed_status = ST_NONE;
		return r;
	endfunction

	function automatic line_row_t start_row();
		line_row_t r;
		int mx, my, k;
		mx = (clamp_size(scr_w) > 0) ? int'(clamp_size(scr_w)) - 1 : 0;
		my = (clamp_size(scr_h) > 0) ? int'(clamp_size(scr_h)) - 1 : 0;
		r = tick_row();
		r.func = FUNC_START;
		k = $urandom_range(0, 99);
		if (k < 50) begin
			r.sx = $urandom_range(0, mx);
			r.sy = $urandom_range(0, my);
			r.ex = r.sx + $urandom_range(0, 24) - 12;
			r.ey = r.sy + $urandom_range(0, 24) - 12;
		end else if (k < 80) begin
			r.sx = $urandom_range(0, mx + 40) - 20;
			r.sy = $urandom_range(0, my + 40) - 20;
			r.ex = $urandom_range(0, mx + 40) - 20;
			r.ey = $urandom_range(0, my + 40) - 20;
		end else if (k < 92) begin
			r.sx = $signed(16'($urandom));
			r.sy = $signed(16'($urandom));
			r.ex = $signed(16'($urandom));
			r.ey = $signed(16'($urandom));
		end else begin
			r.sx = $urandom_range(0, 600) - 300;
			r.sy = $urandom_range(0, 600) - 300;
			r.ex = $urandom_range(0, 600) - 300;
			r.ey = $urandom_range(0, 600) - 300;
		end
		return r;
	endfunction

	function automatic line_row_t mk(logic f, int sx, int sy, int ex, int ey, int colour,
		bit typed = 1'b0, logic [1:0] st = ST_NONE);
		line_row_t r;
		r.func = f; r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey;
		r.color = colour[23:0]; r.typed = typed; r.typed_status = st;
		return r;
	endfunction

	// receiver: random ready, with one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (want_hold) begin
				want_hold = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready = 1'b0;
			end else if (quiet) begin
				rsp_ch.ready = 1'b1;
			end else begin
				case ($urandom_range(0, 19))
					0, 1, 2: rsp_ch.ready = 1'b0;
					3: begin
						rsp_ch.ready = 1'b0;
						repeat ($urandom_range(10, 50)) @(negedge clk);
					end
					default: rsp_ch.ready = 1'b1;
				endcase
			end
		end
	end

	// response checker
	always @(posedge clk) begin
		pixel_word_t got, exp_w;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status = rsp_ch.status;
			got.px = rsp_ch.pixel_x;
			got.py = rsp_ch.pixel_y;
			got.addr = rsp_ch.pixel_addr;
			got.color = rsp_ch.pixel_color;
			got.last = rsp_ch.last_pixel;
			if (pixels_due.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected word: status %0d x %0d y %0d", got.status,
						got.px, got.py);
				mismatches++;
			end else begin
				exp_w = pixels_due.pop_front();
				if (got !== exp_w) begin
					if (mismatches < 10)
						$display({"mismatch: exp st %0d x %0d y %0d a %h c %h l %0d, ",
							"got st %0d x %0d y %0d a %h c %h l %0d"},
							exp_w.status, exp_w.px, exp_w.py, exp_w.addr, exp_w.color,
							exp_w.last, got.status, got.px, got.py, got.addr,
							got.color, got.last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		line_row_t dir_rows[$];
		line_row_t r;
		int widths[6], heights[6];
		int sent, budget, n;
		bit held, paused;

		req_ch.valid = 1'b0;
		req_ch.func = FUNC_TICK;
		req_ch.start_x = '0;
		req_ch.start_y = '0;
		req_ch.end_x = '0;
		req_ch.end_y = '0;
		req_ch.draw_color = '0;
		held = 1'b0;
		paused = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		dir_rows = '{
			mk(FUNC_TICK, 0, 0, 0, 0, 0, 1'b1, ST_NONE),
			mk(FUNC_START, -5, 10, -1, 200, 'h123456, 1'b1, ST_REJECT),
			mk(FUNC_START, 0, 0, 639, 479, 'hffffff, 1'b1, ST_ACCEPT),
			mk(FUNC_TICK, 0, 0, 0, 0, 0), mk(FUNC_TICK, 0, 0, 0, 0, 0),
			mk(FUNC_START, -32768, -32768, 32767, 32767, 0),
			mk(FUNC_TICK, -1, -1, -1, -1, 'hffffff), mk(FUNC_TICK, 0, 0, 0, 0, 0),
			// equal spans step along y
			mk(FUNC_START, 10, 10, 13, 13, 'h00ff00),
			mk(FUNC_TICK, 0, 0, 0, 0, 0), mk(FUNC_TICK, 0, 0, 0, 0, 0),
			mk(FUNC_TICK, 0, 0, 0, 0, 0), mk(FUNC_TICK, 0, 0, 0, 0, 0),
			mk(FUNC_TICK, 0, 0, 0, 0, 0, 1'b1, ST_NONE),
			mk(FUNC_START, 100, 50, 98, 40, 'h0000ff), mk(FUNC_TICK, 0, 0, 0, 0, 0),
			// corner point whose top-edge crossing lies left of the screen
			mk(FUNC_START, -10, -2, 5, 20, 'h800000), mk(FUNC_TICK, 0, 0, 0, 0, 0),
			mk(FUNC_START, -10, 5, 5, -10, 'h000001),
			mk(FUNC_START, 700, 10, 600, 20, 'h5a5a5a), mk(FUNC_TICK, 0, 0, 0, 0, 0),
			mk(FUNC_START, 300, 500, 310, 400, 'ha5a5a5), mk(FUNC_TICK, 0, 0, 0, 0, 0),
			mk(FUNC_START, 5, 5, 5, 5, 'h654321), mk(FUNC_TICK, 0, 0, 0, 0, 0)
		};
		foreach (dir_rows[i]) send_word(dir_rows[i]);

		// screen sizes per phase: reset, extremes, zero, oversized and a small odd size
		widths  = '{640, 1, 4096, 0, 8191, 37};
		heights = '{480, 1, 4096, 5, 100, 23};
		sent = 0;
		for (int p = 0; p < 6; p++) begin
			if (p > 0) begin
				write_reg(REG_WIDTH, widths[p]);
				write_reg(REG_HEIGHT, heights[p]);
			end
			quiet = (p == 2);
			budget = sent + 125;
			while (sent < budget) begin
				r = start_row();
				send_word(r);
				sent++;
				if (p == 1 && !held && sent >= budget - 70) begin
					want_hold = 1'b1;
					held = 1'b1;
				end
				if (p == 3 && !paused && sent >= budget - 70) begin
					wait_drained();
					paused = 1'b1;
				end
				if (drawing && $urandom_range(0, 9) < 7)
					n = ((pix_left < 60) ? pix_left + 1 : 60) + $urandom_range(0, 2);
				else
					n = $urandom_range(0, 8);
				repeat (n) begin
					send_word(tick_row());
					sent++;
				end
			end
		end
		@(negedge clk);
		req_ch.valid = 1'b0;
		wait_drained();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pixels_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ clipped_line_rasterizer_top.f @@
hdl/crl_pkg.sv
hdl/crl_req_if.sv
hdl/crl_rsp_if.sv
hdl/crl_div.sv
hdl/clipped_line_rasterizer_top.sv
tb/tb_clipped_line_rasterizer_top.sv
